// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the line-store pixel converter RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define PDL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checked at every clock edge, reset included.
`define PDL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define PDL_ASSERT(lbl, clk, rst_n, prop)
`define PDL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/pdl_pkg.sv =====
// Shared types, constants and sizes for the PAL delay-line YUV to RGB block.
// No dependencies.
`default_nettype none
package pdl_pkg;

    localparam int LINE_WIDTH = 1024;
    localparam int ADDR_W     = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int COL_W      = 10;
    localparam int COL_EXT_W  = ((ADDR_W > COL_W) ? ADDR_W : COL_W) + 1;

    localparam logic signed [15:0] U_TO_G_COEF = -16'sd12728;
    localparam logic signed [15:0] V_TO_G_COEF = 16'sd32152;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic signed [15:0] luma;
        logic signed [15:0] chroma_u;
        logic signed [15:0] chroma_v;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_out;

    typedef struct packed {
        logic signed [15:0] u;
        logic signed [15:0] v;
    } t_chroma;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] us;
        logic signed [15:0] vs;
    } t_math_in;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_chroma           wr_data;
    } t_store_req;

endpackage
`default_nettype wire

// ===== rtl/core/pdl_line_store.sv =====
// Previous-line chroma store: one synchronous RAM, registered read, and the
// zero-fill sweep after reset. Depends on pdl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pdl_line_store (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pdl_pkg::t_store_req  i_req,
    output pdl_pkg::t_chroma     o_rd_data,
    output logic                 o_clear_busy
);
    import pdl_pkg::*;

    t_chroma           r_mem [LINE_WIDTH];
    t_chroma           r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    t_chroma           w_wd;

    // Sweep zeros through every entry after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(LINE_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else begin
            w_we = i_req.wr_en;
            w_wa = i_req.wr_addr;
            w_wd = i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clr_busy;

    `PDL_ASSERT(a_no_read_in_clear, i_clk, i_rst_n, r_clr_busy |-> !i_req.rd_en)
    `PDL_ASSERT(a_no_write_in_clear, i_clk, i_rst_n, r_clr_busy |-> !i_req.wr_en)
    `PDL_ASSERT(a_clear_full_sweep, i_clk, i_rst_n,
        $fell(r_clr_busy) |-> $past(r_clr_addr) == ADDR_W'(LINE_WIDTH - 1))

endmodule
`default_nettype wire

// ===== rtl/core/pdl_color_math.sv =====
// Color matrix pipeline: products, green sum and byte clamps over three stages.
// Depends on pdl_pkg.
`default_nettype none
module pdl_color_math (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  pdl_pkg::t_math_in    i_math,
    output logic                 o_ready,
    output logic                 o_valid,
    output pdl_pkg::t_pixel_out  o_pixel,
    input  wire                  i_stall
);
    import pdl_pkg::*;

    function automatic logic [7:0] to_byte(input logic signed [15:0] x);
        logic [7:0] res;
        if (x[15]) begin
            res = 8'd0;
        end else if (x[14]) begin
            res = 8'd255;
        end else begin
            res = x[13:6];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] d);
        logic signed [15:0] res;
        if (d[16] != d[15]) begin
            res = d[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            res = d[15:0];
        end
        return res;
    endfunction

    // stage 2: sums in
    logic               r_s2_valid;
    t_math_in           r_s2;
    // stage 3: products and red/blue
    logic               r_s3_valid;
    logic signed [15:0] r_s3_y;
    logic signed [15:0] r_s3_vs;
    logic signed [15:0] r_s3_gu;
    logic signed [15:0] r_s3_gv;
    logic [7:0]         r_s3_red;
    logic [7:0]         r_s3_blue;
    // stage 4: output register
    logic               r_s4_valid;
    t_pixel_out         r_s4_pix;

    logic               w_rdy2, w_rdy3, w_rdy4;
    logic signed [31:0] w_prod_u, w_prod_v;
    logic signed [15:0] w_red, w_blue;
    logic signed [16:0] w_gv_diff;
    logic signed [15:0] w_g1, w_g;

    assign w_rdy4 = !r_s4_valid || !i_stall;
    assign w_rdy3 = !r_s3_valid || w_rdy4;
    assign w_rdy2 = !r_s2_valid || w_rdy3;

    assign w_prod_u  = 32'(r_s2.us) * 32'(U_TO_G_COEF);
    assign w_prod_v  = 32'(r_s2.vs) * 32'(V_TO_G_COEF);
    assign w_red     = r_s2.y + r_s2.vs;
    assign w_blue    = r_s2.y + r_s2.us;

    assign w_gv_diff = 17'(r_s3_gv) - 17'(r_s3_vs);
    assign w_g1      = r_s3_y + r_s3_gu;
    assign w_g       = w_g1 + sat16(w_gv_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy2) r_s2_valid <= i_valid;
            if (w_rdy3) r_s3_valid <= r_s2_valid;
            if (w_rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2 <= i_math;
        end
        if (w_rdy3) begin
            r_s3_y    <= r_s2.y;
            r_s3_vs   <= r_s2.vs;
            r_s3_gu   <= w_prod_u[31:16];
            r_s3_gv   <= w_prod_v[31:16];
            r_s3_red  <= to_byte(w_red);
            r_s3_blue <= to_byte(w_blue);
        end
        if (w_rdy4) begin
            r_s4_pix.red   <= r_s3_red;
            r_s4_pix.green <= to_byte(w_g);
            r_s4_pix.blue  <= r_s3_blue;
        end
    end

    assign o_ready = w_rdy2;
    assign o_valid = r_s4_valid;
    assign o_pixel = r_s4_pix;

endmodule
`default_nettype wire

// ===== rtl/core/pal_delay_line_yuv_to_rgb.sv =====
// PAL delay-line chroma average and YUV to RGB, one pixel item per clock.
// Path: line-store read, chroma sum, products, green sum and clamp, each step
// registered in turn. Throughput: one item per cycle while neither the output
// stall nor the clearing sweep holds the input, limited by the single read and
// write port of the line store.
// Reset: synchronous, active low; afterwards a zero-fill sweep through every
// line-store entry runs while input items are stalled.
`default_nettype none
`include "assert_macros.svh"
module pal_delay_line_yuv_to_rgb (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  pdl_pkg::t_pixel_in   i_in_pixel,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output pdl_pkg::t_pixel_out  o_out_pixel,
    input  wire                  i_out_stall
);
    import pdl_pkg::*;

    // Stage 1: item waits for its line-store read data here.
    logic               r_s1_valid;
    t_pixel_in          r_s1_pix;
    logic               r_s1_inr;
    logic [ADDR_W-1:0]  r_s1_addr;
    // Forwarding: the item ahead wrote this column in the same cycle that
    // this item's read was issued, so the RAM returned the older entry.
    logic               r_fwd;
    t_chroma            r_fwd_data;

    logic [COL_EXT_W-1:0] w_col_ext;
    logic                 w_in_inr;
    logic [ADDR_W-1:0]    w_in_addr;
    logic                 w_accept;
    logic                 w_s1_ready;
    logic                 w_s1_wr;
    logic                 w_cm_ready;
    logic                 w_clr_busy;
    t_store_req           w_req;
    t_chroma              w_rd_data;
    t_chroma              w_prev;
    t_math_in             w_math;

    // Columns past the line store read as zero and write nothing.
    assign w_col_ext = COL_EXT_W'(i_in_pixel.column);
    assign w_in_inr  = w_col_ext < COL_EXT_W'(LINE_WIDTH);
    assign w_in_addr = w_col_ext[ADDR_W-1:0];

    assign w_s1_ready = !r_s1_valid || w_cm_ready;
    assign o_in_stall = !w_s1_ready || w_clr_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Write back the current chroma as the item leaves stage 1.
    assign w_s1_wr = r_s1_valid && w_cm_ready && r_s1_inr;

    always_comb begin
        w_req.rd_en     = w_accept;
        w_req.rd_addr   = w_in_addr;
        w_req.wr_en     = w_s1_wr;
        w_req.wr_addr   = r_s1_addr;
        w_req.wr_data.u = r_s1_pix.chroma_u;
        w_req.wr_data.v = r_s1_pix.chroma_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix     <= i_in_pixel;
            r_s1_inr     <= w_in_inr;
            r_s1_addr    <= w_in_addr;
            r_fwd        <= w_s1_wr && (r_s1_addr == w_in_addr);
            r_fwd_data.u <= r_s1_pix.chroma_u;
            r_fwd_data.v <= r_s1_pix.chroma_v;
        end
    end

    // Pick the previous-line chroma: zero, forwarded, or from the RAM.
    always_comb begin
        priority if (!r_s1_inr) begin
            w_prev = '0;
        end else if (r_fwd) begin
            w_prev = r_fwd_data;
        end else begin
            w_prev = w_rd_data;
        end
        w_math.y  = r_s1_pix.luma;
        w_math.us = r_s1_pix.chroma_u + w_prev.u;
        w_math.vs = r_s1_pix.chroma_v + w_prev.v;
    end

    pdl_line_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_rd_data    (w_rd_data),
        .o_clear_busy (w_clr_busy)
    );

    pdl_color_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_math  (w_math),
        .o_ready (w_cm_ready),
        .o_valid (o_out_valid),
        .o_pixel (o_out_pixel),
        .i_stall (i_out_stall)
    );

    `PDL_ASSERT(a_stall_in_clear, i_clk, i_rst_n, w_clr_busy |-> o_in_stall)
    `PDL_ASSERT(a_s1_hold, i_clk, i_rst_n,
        (r_s1_valid && !w_cm_ready) |=> (r_s1_valid && $stable(r_s1_pix)))
    `PDL_ASSERT(a_wr_from_valid, i_clk, i_rst_n,
        w_req.wr_en |-> (r_s1_valid && r_s1_inr && !w_clr_busy))

endmodule
`default_nettype wire

// ===== tb/pdl_checker.sv =====
// Checker for the PAL delay-line YUV to RGB block: watches both item channels,
// keeps its own copy of the previous-line chroma store and compares every pixel.
// Depends on pdl_pkg for the pixel item types and the line store size.
module pdl_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  pdl_pkg::t_pixel_in  i_in_pixel,
    input  wire                 i_in_stall,
    input  wire                 i_out_valid,
    input  pdl_pkg::t_pixel_out i_out_pixel,
    input  wire                 i_out_stall,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdl_pkg::*;

    localparam int U_GREEN_WEIGHT = -12728;
    localparam int V_GREEN_WEIGHT = 32152;
    localparam int CHAN_SHIFT     = 6;

    logic [15:0] line_u [LINE_WIDTH];
    logic [15:0] line_v [LINE_WIDTH];
    t_pixel_out  rgb_fifo [$];
    int          fail_count;

    function automatic logic [7:0] clamp_channel(input logic signed [15:0] sum);
        logic signed [15:0] scaled;
        scaled = sum >>> CHAN_SHIFT;
        if (scaled < 0)
            return 8'd0;
        if (scaled > 255)
            return 8'd255;
        return scaled[7:0];
    endfunction

    // Color from luma and the two chroma sums; all adds wrap at 16 bits,
    // only the V term of green saturates.
    function automatic t_pixel_out chroma_sum_to_rgb(input logic signed [15:0] y,
                                                     input logic signed [15:0] us,
                                                     input logic signed [15:0] vs);
        int                 u_term;
        int                 v_term;
        logic signed [15:0] r_sum;
        logic signed [15:0] b_sum;
        logic signed [15:0] g_sum;
        t_pixel_out         px;
        u_term = (int'(us) * U_GREEN_WEIGHT) >>> 16;
        v_term = ((int'(vs) * V_GREEN_WEIGHT) >>> 16) - int'(vs);
        if (v_term > 32767)
            v_term = 32767;
        else if (v_term < -32768)
            v_term = -32768;
        r_sum = y + vs;
        b_sum = y + us;
        g_sum = y + 16'(u_term);
        g_sum = g_sum + 16'(v_term);
        px.red   = clamp_channel(r_sum);
        px.green = clamp_channel(g_sum);
        px.blue  = clamp_channel(b_sum);
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_out         want;
        logic signed [15:0] prev_u;
        logic signed [15:0] prev_v;
        logic signed [15:0] us;
        logic signed [15:0] vs;
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_WIDTH; i++) begin
                line_u[i] = '0;
                line_v[i] = '0;
            end
            rgb_fifo.delete();
            fail_count = 0;
        end else begin
            // Compare first: a result never belongs to an item taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (rgb_fifo.size() == 0) begin
                    $error("pixel with no item pending: red %0d green %0d blue %0d",
                           i_out_pixel.red, i_out_pixel.green, i_out_pixel.blue);
                    fail_count++;
                end else begin
                    want = rgb_fifo.pop_front();
                    if (i_out_pixel.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, i_out_pixel.red);
                        fail_count++;
                    end
                    if (i_out_pixel.green !== want.green) begin
                        $error("green: expected %0d, actual %0d",
                               want.green, i_out_pixel.green);
                        fail_count++;
                    end
                    if (i_out_pixel.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, i_out_pixel.blue);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                prev_u = '0;
                prev_v = '0;
                if (int'(i_in_pixel.column) < LINE_WIDTH) begin
                    prev_u = line_u[i_in_pixel.column];
                    prev_v = line_v[i_in_pixel.column];
                    line_u[i_in_pixel.column] = i_in_pixel.chroma_u;
                    line_v[i_in_pixel.column] = i_in_pixel.chroma_v;
                end
                us = i_in_pixel.chroma_u + prev_u;
                vs = i_in_pixel.chroma_v + prev_v;
                rgb_fifo.push_back(chroma_sum_to_rgb(i_in_pixel.luma, us, vs));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= rgb_fifo.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the PAL delay-line YUV to RGB block: clock, reset,
// pixel stimulus, output stall and verdict. Depends on pdl_pkg and pdl_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pdl_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int PHASE_ITEMS  = 420;   // three random phases, about 1250 items
    localparam int DRAIN_CYCLES = 16;    // pipeline is 4 deep, leave some slack
    // Slowest run: the clearing sweep, then ~1300 items at up to 85% idle on
    // either side. Take it many times over.
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    t_pixel_in  in_pixel;
    logic       in_stall;
    logic       out_valid;
    t_pixel_out out_pixel;
    logic       out_stall;

    int send_idle_pct = 21;
    int recv_idle_pct = 85;
    int cycle_count   = 0;
    int fail_count;
    int pending;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pal_delay_line_yuv_to_rgb u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_pixel  (in_pixel),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_pixel (out_pixel),
        .i_out_stall (out_stall)
    );

    pdl_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_pixel   (in_pixel),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_pixel  (out_pixel),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the output side at random; the rate changes with the phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Abort the run if it hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic t_pixel_in make_pixel(input logic [9:0] col, input logic [15:0] y,
                                             input logic [15:0] u, input logic [15:0] v);
        t_pixel_in px;
        px.column   = col;
        px.luma     = y;
        px.chroma_u = u;
        px.chroma_v = v;
        return px;
    endfunction

    // Mostly a value inside [lo, hi] so the clamp does not swallow everything,
    // sometimes a full 16-bit value to reach every bit and the wrap cases.
    function automatic logic [15:0] pick_sample(input int lo, input int hi);
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // Offer one item, idling first at the current sender rate, and hold it
    // until the block takes it.
    task automatic send_pixel(input t_pixel_in px);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Scan a short run of columns over several lines in a row, so every pixel
    // after the first line averages with the one stored above it; mix in some
    // lone pixels at any column with any content.
    task automatic send_random_pixels(input int n_items);
        int sent;
        int base;
        int len;
        int lines;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_pixel(make_pixel(10'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom)));
                sent++;
            end else begin
                len   = $urandom_range(4, 24);
                lines = $urandom_range(2, 4);
                base  = $urandom_range(0, LINE_WIDTH - len);
                for (int l = 0; l < lines; l++) begin
                    for (int c = base; c < base + len; c++) begin
                        send_pixel(make_pixel(10'(c), pick_sample(0, 16383),
                                              pick_sample(-4096, 4095),
                                              pick_sample(-4096, 4095)));
                    end
                end
                sent += len * lines;
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_pixel  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, sender idling lightly and receiver heavily.
        // Black, then luma clamped high and low, then mid gray.
        send_pixel(make_pixel(10'd0,    16'h0000, 16'h0000, 16'h0000));
        send_pixel(make_pixel(10'd1023, 16'h7FFF, 16'h0000, 16'h0000));
        send_pixel(make_pixel(10'd1,    16'h8000, 16'h0000, 16'h0000));
        send_pixel(make_pixel(10'd2,    16'h2000, 16'h0000, 16'h0000));
        // Chroma extremes, then a second line at the same columns whose sums wrap.
        send_pixel(make_pixel(10'd3,    16'h2000, 16'h7FFF, 16'h8000));
        send_pixel(make_pixel(10'd3,    16'h2000, 16'h0001, 16'hFFFF));
        send_pixel(make_pixel(10'd4,    16'h2000, 16'h8000, 16'h7FFF));
        send_pixel(make_pixel(10'd4,    16'h2000, 16'h8000, 16'h7FFF));
        // Luma plus chroma sum wraps past either end.
        send_pixel(make_pixel(10'd5,    16'h7FFF, 16'h0001, 16'h0001));
        send_pixel(make_pixel(10'd6,    16'h8000, 16'hFFFF, 16'hFFFF));
        // Revisit the first and last columns of the store.
        send_pixel(make_pixel(10'd1023, 16'h1000, 16'h07D0, 16'hF830));
        send_pixel(make_pixel(10'd0,    16'h1000, 16'hF830, 16'h07D0));
        send_pixel(make_pixel(10'd1023, 16'h1000, 16'h07D0, 16'hF830));
        // Alternating bit patterns in every field.
        send_pixel(make_pixel(10'h155,  16'h5555, 16'h5555, 16'hAAAA));
        send_pixel(make_pixel(10'h2AA,  16'hAAAA, 16'hAAAA, 16'h5555));
        send_pixel(make_pixel(10'h155,  16'h3FFF, 16'hAAAA, 16'h5555));
        // Opposite chroma on consecutive lines cancels to gray.
        send_pixel(make_pixel(10'd512,  16'h0FA0, 16'h0BB8, 16'hF448));
        send_pixel(make_pixel(10'd512,  16'h0FA0, 16'hF448, 16'h0BB8));
        // Strong colors that push green to each end.
        send_pixel(make_pixel(10'd7,    16'h2000, 16'h4000, 16'h4000));
        send_pixel(make_pixel(10'd8,    16'h2000, 16'hC000, 16'hC000));

        send_random_pixels(PHASE_ITEMS);

        send_idle_pct = 85;
        recv_idle_pct = 21;
        send_random_pixels(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_pixels(PHASE_ITEMS);
        in_valid <= 1'b0;

        // The pending count is registered, so it trails the checker's queue; let it catch up before polling.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== pal_delay_line_yuv_to_rgb.f =====
+incdir+rtl/core
rtl/core/pdl_pkg.sv
rtl/core/pdl_line_store.sv
rtl/core/pdl_color_math.sv
rtl/core/pal_delay_line_yuv_to_rgb.sv
tb/pdl_checker.sv
tb/testbench.sv
